// ----- rtl/core/msts_pkg.sv -----
// Shared types and constants for the multi-slot timer scheduler.
// Item structs, operation and unit codes, sequencer states, unit scaling.
`timescale 1ns / 1ps

package msts_pkg;

	localparam int SLOT_W = 4;
	localparam int MS_W = 32;
	localparam int COUNT_W = 16;
	localparam int UNIT_W = 3;
	localparam int SCALE_W = 27;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	localparam logic [UNIT_W-1:0] UNIT_MS   = 3'd0;
	localparam logic [UNIT_W-1:0] UNIT_SEC  = 3'd1;
	localparam logic [UNIT_W-1:0] UNIT_MIN  = 3'd2;
	localparam logic [UNIT_W-1:0] UNIT_HOUR = 3'd3;
	localparam logic [UNIT_W-1:0] UNIT_DAY  = 3'd4;

	localparam logic [SCALE_W-1:0] MS_PER_SEC = 27'd1000;
	localparam logic [SCALE_W-1:0] SEC_PER_MIN = 27'd60;
	localparam logic [SCALE_W-1:0] MIN_PER_HOUR = 27'd60;
	localparam logic [SCALE_W-1:0] HOUR_PER_DAY = 27'd24;

	typedef struct packed {
		logic [1:0]         operation;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] delay_value;
		logic [UNIT_W-1:0]  delay_units;
		logic [COUNT_W-1:0] period_value;
		logic [UNIT_W-1:0]  period_units;
		logic [MS_W-1:0]    now_ms;
	} sched_in_t;

	typedef struct packed {
		logic              fired;
		logic [SLOT_W-1:0] fired_slot;
		logic              next_valid;
		logic [MS_W-1:0]   next_delay_ms;
		logic              last;
	} sched_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_TICK,
		ST_MIN,
		ST_EMIT
	} sched_state_t;

	// Milliseconds per unit; unknown codes count as milliseconds.
	function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] unit);
		logic [SCALE_W-1:0] s;
		begin
			unique case (unit)
				UNIT_SEC:  s = MS_PER_SEC;
				UNIT_MIN:  s = SCALE_W'(MS_PER_SEC * SEC_PER_MIN);
				UNIT_HOUR: s = SCALE_W'(MS_PER_SEC * SEC_PER_MIN * MIN_PER_HOUR);
				UNIT_DAY:  s = SCALE_W'(MS_PER_SEC * SEC_PER_MIN * MIN_PER_HOUR
					* HOUR_PER_DAY);
				default:   s = SCALE_W'(1);
			endcase
			return s;
		end
	endfunction

endpackage

// ----- rtl/core/multi_slot_timer_scheduler_top.sv -----
// Top level of the multi-slot timer scheduler: slot store, sequencer and result register.
// Depends on msts_pkg.
`timescale 1ns / 1ps

// Timer slots served one item at a time through one shared multiplier; the
// slot logic visits the slots in turn. USED is the smaller of SLOT_COUNT and
// 16. A schedule or cancel item gets an update step, then a pass over the
// slots to find the smallest remaining delay. Its result is then loaded into
// the output register as soon as that register is free. Any other operation
// code goes straight to the minimum search. A tick makes one pass ageing and
// reloading the slots and another on the minimum. It then walks the slots from
// 0 up to the last expired one, in turn, and gives a result for every expired
// slot. A result that is due waits while the output register is full and not
// being taken. in_ready is low while an item is in work. A finished result
// sits in the output register, so the next item may be taken while it waits.
module multi_slot_timer_scheduler_top
	import msts_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sched_in_t  in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output sched_out_t out_item,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	localparam int USED = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
	localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED - 1);
	localparam logic [SLOT_W:0] USED_LIM = (SLOT_W + 1)'(USED);

	sched_state_t state_q, state_d;

	logic [MS_W-1:0]    remaining_q [USED];
	logic [COUNT_W-1:0] reload_cnt_q [USED];
	logic [UNIT_W-1:0]  reload_unit_q [USED];
	logic [USED-1:0]    armed_q;
	logic [USED-1:0]    hit_q;
	logic               hit_any_q;
	logic [IDX_W-1:0]   last_hit_q;
	logic [IDX_W-1:0]   idx_q;
	logic [MS_W-1:0]    last_tick_q;
	logic [MS_W-1:0]    elapsed_q;
	logic [MS_W-1:0]    best_q;
	logic               any_q;
	logic               running_q;
	sched_in_t          item_q;
	logic               out_valid_q;
	sched_out_t         out_q;

	// Shared unit: one multiplier for unit conversion, used for new delays and reloads.
	logic [COUNT_W-1:0] mul_cnt;
	logic [UNIT_W-1:0]  mul_unit;
	logic [MS_W-1:0]    mul_p;
	logic [MS_W-1:0]    rem_cur;
	logic               expire;
	logic               slot_ok;
	logic [IDX_W-1:0]   slot_idx;

	// Sequencer outputs
	logic       out_free;
	logic       out_load;
	logic       emit_adv;
	logic       emit_done;
	sched_out_t out_d;
	logic       next_valid;

	assign rem_cur = remaining_q[idx_q];
	assign slot_ok = {1'b0, item_q.slot} < USED_LIM;
	assign slot_idx = item_q.slot[IDX_W-1:0];
	assign expire = rem_cur <= elapsed_q;
	assign next_valid = running_q & any_q;

	always_comb begin
		if (state_q == ST_APPLY) begin
			mul_cnt = item_q.delay_value;
			mul_unit = item_q.delay_units;
		end else begin
			mul_cnt = reload_cnt_q[idx_q];
			mul_unit = reload_unit_q[idx_q];
		end
		mul_p = MS_W'(mul_cnt) * MS_W'(unit_scale(mul_unit));
	end

	assign out_free = !out_valid_q || out_ready;

	// Output control
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		emit_adv = 1'b0;
		emit_done = 1'b0;
		out_d = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EMIT: begin
				if (hit_any_q) begin
					if (hit_q[idx_q]) begin
						out_load = out_free;
						out_d.fired = 1'b1;
						out_d.fired_slot = SLOT_W'(idx_q);
						if (idx_q == last_hit_q) begin
							out_d.last = 1'b1;
							out_d.next_valid = next_valid;
							out_d.next_delay_ms = next_valid ? best_q : '0;
							emit_done = out_free;
						end
						emit_adv = out_free;
					end else begin
						emit_adv = 1'b1;
					end
				end else begin
					out_load = out_free;
					out_d.last = 1'b1;
					out_d.next_valid = next_valid;
					out_d.next_delay_ms = next_valid ? best_q : '0;
					emit_done = out_free;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_item.operation)
						OP_SCHEDULE, OP_CANCEL: state_d = ST_APPLY;
						OP_TICK:                state_d = ST_TICK;
						default:                state_d = ST_MIN;
					endcase
				end
			end
			ST_APPLY: state_d = ST_MIN;
			ST_TICK: begin
				if (idx_q == LAST_IDX) state_d = ST_MIN;
			end
			ST_MIN: begin
				if (idx_q == LAST_IDX) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			armed_q <= '0;
			hit_q <= '0;
			hit_any_q <= 1'b0;
			last_hit_q <= '0;
			idx_q <= '0;
			last_tick_q <= '0;
			any_q <= 1'b0;
			running_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) running_q <= cfg_wdata;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					hit_q <= '0;
					hit_any_q <= 1'b0;
					any_q <= 1'b0;
					if (in_valid && in_item.operation == OP_TICK) begin
						last_tick_q <= in_item.now_ms;
					end
				end
				ST_APPLY: begin
					if (slot_ok) armed_q[slot_idx] <= (item_q.operation == OP_SCHEDULE);
				end
				ST_TICK: begin
					if (armed_q[idx_q] && expire) begin
						hit_q[idx_q] <= 1'b1;
						hit_any_q <= 1'b1;
						last_hit_q <= idx_q;
						if (reload_cnt_q[idx_q] == '0) armed_q[idx_q] <= 1'b0;
					end
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				ST_MIN: begin
					if (armed_q[idx_q] && (!any_q || rem_cur < best_q)) begin
						any_q <= 1'b1;
					end
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				ST_EMIT: begin
					if (emit_adv && idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Slot store and payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
			// elapsed since last tick; schedule uses it to offset the new delay
			elapsed_q <= in_item.now_ms - last_tick_q;
		end
		if (out_load) out_q <= out_d;
		unique case (state_q)
			ST_APPLY: begin
				if (slot_ok) begin
					if (item_q.operation == OP_SCHEDULE) begin
						remaining_q[slot_idx] <= mul_p + elapsed_q;
						reload_cnt_q[slot_idx] <= item_q.period_value;
						reload_unit_q[slot_idx] <= item_q.period_units;
					end else begin
						remaining_q[slot_idx] <= '0;
					end
				end
			end
			ST_TICK: begin
				if (armed_q[idx_q]) begin
					if (!expire) begin
						remaining_q[idx_q] <= rem_cur - elapsed_q;
					end else if (reload_cnt_q[idx_q] != '0) begin
						remaining_q[idx_q] <= mul_p;
					end else begin
						remaining_q[idx_q] <= '0;
					end
				end
			end
			ST_MIN: begin
				if (armed_q[idx_q] && (!any_q || rem_cur < best_q)) best_q <= rem_cur;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule
